[design/glcd_page_column_sequencer_unit_defines.svh]
// Assertion macros shared by the page/column sequencer modules.
// Each macro expects signals named clk and rst in the using module.
`ifndef GLCD_PAGE_COLUMN_SEQUENCER_UNIT_DEFINES_SVH
`define GLCD_PAGE_COLUMN_SEQUENCER_UNIT_DEFINES_SVH

// Condition holds at every clock edge outside reset.
`define GLCD_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("sequencer invariant violated");

// Consequent holds in the same cycle as the antecedent.
`define GLCD_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sequencer implication violated");

// Consequent holds in the cycle after the antecedent.
`define GLCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequencer next-cycle check violated");

`endif

[design/glcd_pcs_pkg.sv]
// Shared types, constants and helper functions for the page/column sequencer.
// No dependencies; every other design file but the assertion macro header imports this package.
package glcd_pcs_pkg;

  localparam int DISPLAY_WIDTH    = 128;
  localparam int CONTROLLER_WIDTH = 64;
  localparam int PAGE_COUNT       = 8;

  localparam int OP_W    = 3;
  localparam int BYTE_W  = 8;
  localparam int COL_W   = 7;
  localparam int PAGE_W  = 3;
  localparam int LINE_W  = 6;
  localparam int STEP_W  = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BYTE_W-1:0] CMD_PAGE  = 8'hB8;
  localparam logic [BYTE_W-1:0] CMD_COL   = 8'h40;
  localparam logic [BYTE_W-1:0] CMD_START = 8'hC0;
  localparam logic [BYTE_W-1:0] CMD_ON    = 8'h3F;
  localparam logic [BYTE_W-1:0] COL_MASK  = 8'h3F;

  // Step index of the final transfer for each kind of job.
  localparam logic [STEP_W-1:0] LAST_STEP_DATA  = 3'd5;
  localparam logic [STEP_W-1:0] LAST_STEP_ADDR  = 3'd4;
  localparam logic [STEP_W-1:0] LAST_STEP_BCAST = 3'd1;

  // Positions within the page-set plus column-set address sequence.
  localparam logic [STEP_W-1:0] ADDR_PAGE_LEFT  = 3'd0;
  localparam logic [STEP_W-1:0] ADDR_PAGE_RIGHT = 3'd1;
  localparam logic [STEP_W-1:0] ADDR_COL_LEFT   = 3'd2;
  localparam logic [STEP_W-1:0] ADDR_COL_RIGHT  = 3'd3;

  typedef enum logic [OP_W-1:0] {
    OP_DATA_WRITE  = 3'd0,
    OP_DATA_READ   = 3'd1,
    OP_DUMMY_READ  = 3'd2,
    OP_SET_ADDRESS = 3'd3,
    OP_START_LINE  = 3'd4,
    OP_DISPLAY_ON  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    JOB_DATA  = 2'd0,
    JOB_ADDR  = 2'd1,
    JOB_BCAST = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t               kind;
    logic                    rnw;
    logic                    wrap;
    logic                    chip;
    logic [BYTE_W-1:0]       data_byte;
    logic [PAGE_W-1:0]       page;
    logic [COL_W-1:0]        col;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } queue_head_t;

  typedef struct packed {
    logic              chip;
    logic              reg_select;
    logic              read_not_write;
    logic [BYTE_W-1:0] bus_byte;
    logic              last;
  } bus_tx_t;

  // Controller that owns a column; columns from CONTROLLER_WIDTH (64) up belong to the right half.
  function automatic logic owner(logic [COL_W-1:0] col);
    return 32'(col) >= CONTROLLER_WIDTH;
  endfunction

endpackage

[design/glcd_cmd_if.sv]
// Command channel into the sequencer: valid/ready handshake plus command fields.
// Depends on glcd_pcs_pkg for field widths.
interface glcd_cmd_if;
  import glcd_pcs_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [BYTE_W-1:0] value;
  logic [COL_W-1:0]  x_pos;
  logic [PAGE_W-1:0] page_sel;
  logic [LINE_W-1:0] line_start;

  modport source(output valid, output op, output value, output x_pos,
                 output page_sel, output line_start, input ready);
  modport sink(input valid, input op, input value, input x_pos,
               input page_sel, input line_start, output ready);
endinterface

[design/glcd_bus_if.sv]
// Bus transaction channel out of the sequencer: valid/ready plus transaction fields.
// Depends on glcd_pcs_pkg for field widths.
interface glcd_bus_if;
  import glcd_pcs_pkg::*;

  logic              valid;
  logic              ready;
  logic              chip;
  logic              reg_select;
  logic              read_not_write;
  logic [BYTE_W-1:0] bus_byte;
  logic              last;

  modport source(output valid, output chip, output reg_select,
                 output read_not_write, output bus_byte, output last, input ready);
  modport sink(input valid, input chip, input reg_select,
               input read_not_write, input bus_byte, input last, output ready);
endinterface

[design/glcd_pcs_front.sv]
// Front end: accepts commands, tracks column and page, and emits one job per recognised command.
// Depends on glcd_pcs_pkg, glcd_cmd_if and the assertion macro header.
`include "glcd_page_column_sequencer_unit_defines.svh"

module glcd_pcs_front (
  input  logic                 clk,
  input  logic                 rst,
  glcd_cmd_if.sink             cmd,
  input  logic                 full,
  output logic                 push,
  output glcd_pcs_pkg::job_t   job
);
  import glcd_pcs_pkg::*;

  logic [COL_W-1:0]  column;
  logic [COL_W-1:0]  column_next;
  logic [PAGE_W-1:0] page_reg;
  logic [PAGE_W-1:0] page_reg_next;
  logic [PAGE_W-1:0] page_inc;
  logic              row_end;
  logic              accept;

  assign cmd.ready = !full;
  assign accept    = cmd.valid && cmd.ready;
  assign row_end   = column == COL_W'(DISPLAY_WIDTH - 1);
  assign page_inc  = (page_reg == PAGE_W'(PAGE_COUNT - 1)) ? '0 : page_reg + 1'b1;

  always_comb begin
    push          = 1'b0;
    column_next   = column;
    page_reg_next = page_reg;
    job.kind      = JOB_DATA;
    job.rnw       = 1'b0;
    job.wrap      = 1'b0;
    job.chip      = owner(column);
    job.data_byte = '0;
    job.page      = page_reg;
    job.col       = column;
    if (accept) begin
      unique case (op_t'(cmd.op))
        OP_DATA_WRITE, OP_DATA_READ: begin
          push          = 1'b1;
          job.rnw       = op_t'(cmd.op) == OP_DATA_READ;
          job.data_byte = (op_t'(cmd.op) == OP_DATA_WRITE) ? cmd.value : '0;
          job.wrap      = row_end;
          if (row_end) begin
            column_next   = '0;
            page_reg_next = page_inc;
          end else begin
            column_next = column + 1'b1;
          end
        end
        OP_DUMMY_READ: begin
          push    = 1'b1;
          job.rnw = 1'b1;
        end
        OP_SET_ADDRESS: begin
          push          = 1'b1;
          job.kind      = JOB_ADDR;
          page_reg_next = PAGE_W'(32'(cmd.page_sel) % PAGE_COUNT);
          column_next   = COL_W'(32'(cmd.x_pos) % DISPLAY_WIDTH);
        end
        OP_START_LINE: begin
          push          = 1'b1;
          job.kind      = JOB_BCAST;
          job.data_byte = CMD_START | {{(BYTE_W - LINE_W){1'b0}}, cmd.line_start};
        end
        OP_DISPLAY_ON: begin
          push          = 1'b1;
          job.kind      = JOB_BCAST;
          job.data_byte = CMD_ON;
        end
        default: begin
          push = 1'b0;
        end
      endcase
      // Address-moving jobs carry the address they leave behind.
      job.page = page_reg_next;
      job.col  = column_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column   <= '0;
      page_reg <= '0;
    end else begin
      column   <= column_next;
      page_reg <= page_reg_next;
    end
  end

  `GLCD_ASSERT_ALWAYS(a_column_range, 32'(column) < DISPLAY_WIDTH)
  `GLCD_ASSERT_ALWAYS(a_page_range, 32'(page_reg) < PAGE_COUNT)
  `GLCD_ASSERT_NEXT(a_wrap_clears_column, push && job.wrap, column == '0)

endmodule

[design/glcd_pcs_queue.sv]
// Short job queue between the front end and the bus sequencer.
// Depends on glcd_pcs_pkg and the assertion macro header.
`include "glcd_page_column_sequencer_unit_defines.svh"

module glcd_pcs_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  glcd_pcs_pkg::job_t          push_job,
  output logic                        full,
  input  logic                        pop,
  output glcd_pcs_pkg::queue_head_t   head
);
  import glcd_pcs_pkg::*;

  job_t               entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;

  assign full       = count == COUNT_W'(QUEUE_DEPTH);
  assign head.valid = count != '0;
  assign head.job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `GLCD_ASSERT_ALWAYS(a_count_bound, 32'(count) <= QUEUE_DEPTH)
  `GLCD_ASSERT_IMPLIES(a_no_overflow, push, !full || pop)
  `GLCD_ASSERT_IMPLIES(a_no_underflow, pop, head.valid)

endmodule

[design/glcd_pcs_back.sv]
// Back end: expands each queued job into bus transfers, one per cycle while the bus is ready, into an output register.
// Depends on glcd_pcs_pkg, glcd_bus_if and the assertion macro header.
`include "glcd_page_column_sequencer_unit_defines.svh"

module glcd_pcs_back (
  input  logic                        clk,
  input  logic                        rst,
  input  glcd_pcs_pkg::queue_head_t   head,
  output logic                        pop,
  glcd_bus_if.source                  bus
);
  import glcd_pcs_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              out_valid;
  logic              out_valid_next;
  bus_tx_t           out_tx;
  bus_tx_t           tx;
  logic              advance;

  // Page-set on both halves, column reset on both, then the column set on its owner.
  function automatic bus_tx_t addr_tx(logic [STEP_W-1:0] a, logic [PAGE_W-1:0] page,
                                      logic [COL_W-1:0] col);
    bus_tx_t t;
    t.reg_select     = 1'b0;
    t.read_not_write = 1'b0;
    t.last           = 1'b0;
    unique case (a)
      ADDR_PAGE_LEFT: begin
        t.chip     = 1'b0;
        t.bus_byte = CMD_PAGE | {{(BYTE_W - PAGE_W){1'b0}}, page};
      end
      ADDR_PAGE_RIGHT: begin
        t.chip     = 1'b1;
        t.bus_byte = CMD_PAGE | {{(BYTE_W - PAGE_W){1'b0}}, page};
      end
      ADDR_COL_LEFT: begin
        t.chip     = 1'b0;
        t.bus_byte = CMD_COL;
      end
      ADDR_COL_RIGHT: begin
        t.chip     = 1'b1;
        t.bus_byte = CMD_COL;
      end
      default: begin
        t.chip     = owner(col);
        t.bus_byte = CMD_COL | ({{(BYTE_W - COL_W){1'b0}}, col} & COL_MASK);
      end
    endcase
    return t;
  endfunction

  always_comb begin
    tx = '0;
    unique case (head.job.kind)
      JOB_DATA: begin
        if (step == '0) begin
          tx.chip           = head.job.chip;
          tx.reg_select     = 1'b1;
          tx.read_not_write = head.job.rnw;
          tx.bus_byte       = head.job.data_byte;
          tx.last           = !head.job.wrap;
        end else begin
          tx      = addr_tx(step - 1'b1, head.job.page, head.job.col);
          tx.last = step == LAST_STEP_DATA;
        end
      end
      JOB_ADDR: begin
        tx      = addr_tx(step, head.job.page, head.job.col);
        tx.last = step == LAST_STEP_ADDR;
      end
      JOB_BCAST: begin
        tx.chip     = step[0];
        tx.bus_byte = head.job.data_byte;
        tx.last     = step == LAST_STEP_BCAST;
      end
      default: begin
        tx.last = 1'b1;
      end
    endcase
  end

  assign advance = head.valid && (!out_valid || bus.ready);
  assign pop     = advance && tx.last;

  always_comb begin
    step_next      = step;
    out_valid_next = out_valid;
    if (advance) begin
      step_next      = tx.last ? '0 : step + 1'b1;
      out_valid_next = 1'b1;
    end else if (bus.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tx <= tx;
    end
  end

  assign bus.valid          = out_valid;
  assign bus.chip           = out_tx.chip;
  assign bus.reg_select     = out_tx.reg_select;
  assign bus.read_not_write = out_tx.read_not_write;
  assign bus.bus_byte       = out_tx.bus_byte;
  assign bus.last           = out_tx.last;

  `GLCD_ASSERT_ALWAYS(a_step_range, step <= LAST_STEP_DATA)
  `GLCD_ASSERT_IMPLIES(a_midjob_has_head, step != '0, head.valid)
  `GLCD_ASSERT_NEXT(a_step_advances, advance && !tx.last, step == $past(step) + 1'b1)

endmodule

[design/glcd_page_column_sequencer_unit.sv]
// A command's first bus transfer is registered in the job queue, then in the output register.
// Throughput: one bus transfer per cycle while the bus is ready; a command expands into
// from one transfer (dummy read, data access within a row) to six (data access that ends a row).
// The back-end sequencer, emitting one transfer per cycle into its output register, sets that.
// Reset (synchronous, active high) clears column and page to zero, empties the job queue and
// drops any pending bus transfer.
module glcd_page_column_sequencer_unit (
  input  logic       clk,
  input  logic       rst,
  glcd_cmd_if.sink   cmd,
  glcd_bus_if.source bus
);
  import glcd_pcs_pkg::*;

  // Jobs flow front -> queue -> back. The front end owns the address state and folds
  // every address change into the job it pushes, so the back end only sequences.
  logic        push;
  logic        full;
  logic        pop;
  job_t        push_job;
  queue_head_t head;

  // Command transfers are taken whenever the queue has room, independent of the bus side.
  glcd_pcs_front u_front (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .full (full),
    .push (push),
    .job  (push_job)
  );

  // Two jobs of slack let the front end keep accepting while a long row-end job drains.
  glcd_pcs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head     (head)
  );

  // The back end turns the head job into bus transfers and retires it on its last transfer.
  glcd_pcs_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .bus  (bus)
  );

endmodule
